// File: rtl/core/disk_image_track_checksum_defines.svh
// Assertion macros for the disk image track checksum block.
// Included by the RTL files that check their own logic; needs clk and rst_n in scope.
`ifndef DISK_IMAGE_TRACK_CHECKSUM_DEFINES_SVH
`define DISK_IMAGE_TRACK_CHECKSUM_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DITC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DITC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DITC_ASSERT_SAME(lbl, ante, cons, msg)
`define DITC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/ditc_pkg.sv
// Package for the disk image track checksum block: widths, codes, event struct, text table.
// No dependencies.
`default_nettype none

package ditc_pkg;

  localparam int unsigned TRACK_COUNT_DEF = 160;
  localparam logic [12:0] TRACK_WORDS_RST = 13'd1408;
  localparam int unsigned TEXT_LEN        = 11;

  // result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_TRACK = 2'd0,
    KIND_DISK  = 2'd1,
    KIND_TEXT  = 2'd2
  } kind_t;

  // result sequencer states
  typedef enum logic [1:0] {
    ST_TRACK,
    ST_DISK,
    ST_TEXT
  } state_t;

  // one finished track handed from the accumulator to the result side
  typedef struct packed {
    logic [31:0] sum_hi;
    logic [31:0] sum_lo;
    logic [7:0]  track;
    logic        last_trk;
    logic [31:0] bytes;
  } trk_evt_t;

  // character set of the text form, first char at the top byte
  localparam logic [8*64-1:0] CHAR_STR =
    ".abcdefghijklmnopqrstuvwxyz%123456789ABCDEFGHIJKLMN/PQRSTUVWXYZ:";

  function automatic logic [7:0] char_of(input logic [5:0] g);
    // char g sits at byte 63-g, i.e. bit offset (~g)*8
    return CHAR_STR[{~g, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/disk_image_track_checksum.sv
// Top level of the disk image track checksum block: word accumulator and result sequencer.
// Depends on ditc_pkg and disk_image_track_checksum_defines.svh.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data_word[31:0]
//   out     | output    | out_valid/out_stall| kind, track index, checksum hi/lo, char, last
//   cfg     | input     | cfg_valid/cfg_ready| cfg_track_words[12:0]
//
// One word is taken per cycle while in_stall is low; a track's sums go into the event slot
// when its last word is taken, and are presented once the result sequencer takes the slot.
// The end of the last track gives 13 words out of the result sequencer, one per cycle unless
// out_stall holds them; words inside a track keep flowing meanwhile, one further track end is
// held in the event slot and the next one waits for the burst.
// in_stall rises only on a track-end word whose event slot is still full.
// Reset (rst_n low at a clock edge) clears all sums and counters; track_words returns to 1408.
`default_nettype none

`include "disk_image_track_checksum_defines.svh"

module disk_image_track_checksum
  import ditc_pkg::*;
#(
  parameter int unsigned TRACK_COUNT = TRACK_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // image words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_data_word,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_track_index,
  output logic [31:0]      out_checksum_high,
  output logic [31:0]      out_checksum_low,
  output logic [7:0]       out_text_char,
  output logic             out_run_last,
  // track length register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_track_words
);

  localparam logic [7:0]  LAST_TRACK = 8'(TRACK_COUNT - 1);
  localparam logic [31:0] BYTES_MUL  = 32'(4 * TRACK_COUNT);
  localparam logic [3:0]  LAST_CHAR  = 4'(TEXT_LEN - 1);

  // ---------------- configuration ----------------
  logic [12:0] track_words_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_words_r <= TRACK_WORDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      track_words_r <= cfg_track_words;
    end
  end

  // ---------------- word accumulator ----------------
  logic [31:0] ts1_r, ts2_r;
  logic [11:0] word_cnt_r;
  logic [7:0]  trk_cnt_r;
  logic        ev_valid_r;
  trk_evt_t    ev_r;

  logic [11:0] last_idx;
  logic [12:0] eff_words;
  logic        at_end;
  logic        in_accept;
  logic        ev_take;
  logic [31:0] ts1_nxt, ts2_nxt;

  assign last_idx  = track_words_r[11:0] - 12'd1;
  assign eff_words = {1'b0, last_idx} + 13'd1;
  assign at_end    = (word_cnt_r == last_idx);
  assign in_stall  = at_end && ev_valid_r && !ev_take;
  assign in_accept = in_valid && !in_stall;
  assign ts1_nxt   = ts1_r + in_data_word;
  assign ts2_nxt   = ts2_r + ts1_nxt;

  // running track sums and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts1_r      <= '0;
      ts2_r      <= '0;
      word_cnt_r <= '0;
      trk_cnt_r  <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        if (at_end) begin
          ts1_r      <= '0;
          ts2_r      <= '0;
          word_cnt_r <= '0;
          trk_cnt_r  <= (trk_cnt_r == LAST_TRACK) ? 8'd0 : trk_cnt_r + 8'd1;
        end else begin
          ts1_r      <= ts1_nxt;
          ts2_r      <= ts2_nxt;
          word_cnt_r <= word_cnt_r + 12'd1;
        end
      end
      if (in_accept && at_end) begin
        ev_valid_r <= 1'b1;
      end else if (ev_take) begin
        ev_valid_r <= 1'b0;
      end
    end
  end

  // finished-track event payload
  always_ff @(posedge clk) begin
    if (in_accept && at_end) begin
      ev_r.sum_hi   <= ts2_nxt;
      ev_r.sum_lo   <= ts1_nxt;
      ev_r.track    <= trk_cnt_r;
      ev_r.last_trk <= (trk_cnt_r == LAST_TRACK);
      ev_r.bytes    <= 32'(eff_words) * BYTES_MUL;
    end
  end

  // ---------------- result sequencer ----------------
  state_t      state_r, state_nxt;
  logic [31:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [63:0] text_r, text_nxt;
  logic [3:0]  char_cnt_r, char_cnt_nxt;
  logic        out_free;

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [31:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [7:0]  chr_r, chr_nxt;
  logic        last_r, last_nxt;

  logic [31:0] d1_fin, d2_fin;

  assign out_free = !out_valid_r || !out_stall;
  // disk sum after feeding 0, then the byte count
  assign d1_fin   = d1_r + bytes_r;
  assign d2_fin   = d2_r + {d1_r[30:0], 1'b0} + bytes_r;

  always_comb begin
    state_nxt     = state_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    bytes_nxt     = bytes_r;
    text_nxt      = text_r;
    char_cnt_nxt  = char_cnt_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    chr_nxt       = chr_r;
    last_nxt      = last_r;
    ev_take       = 1'b0;
    unique case (state_r)
      ST_TRACK: begin
        if (ev_valid_r && out_free) begin
          ev_take       = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_TRACK;
          idx_nxt       = ev_r.track;
          hi_nxt        = ev_r.sum_hi;
          lo_nxt        = ev_r.sum_lo;
          chr_nxt       = 8'd0;
          last_nxt      = !ev_r.last_trk;
          // feed sum2 then sum1 into the disk sums in one step
          d1_nxt        = d1_r + ev_r.sum_hi + ev_r.sum_lo;
          d2_nxt        = d2_r + {d1_r[30:0], 1'b0} + {ev_r.sum_hi[30:0], 1'b0}
                          + ev_r.sum_lo;
          bytes_nxt     = ev_r.bytes;
          if (ev_r.last_trk) begin
            state_nxt = ST_DISK;
          end
        end
      end
      ST_DISK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DISK;
          idx_nxt       = 8'd0;
          hi_nxt        = d2_fin;
          lo_nxt        = d1_fin;
          chr_nxt       = 8'd0;
          last_nxt      = 1'b0;
          text_nxt      = {d2_fin, d1_fin};
          char_cnt_nxt  = 4'd0;
          d1_nxt        = '0;
          d2_nxt        = '0;
          state_nxt     = ST_TEXT;
        end
      end
      ST_TEXT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_TEXT;
          idx_nxt       = 8'd0;
          hi_nxt        = 32'd0;
          lo_nxt        = 32'd0;
          chr_nxt       = char_of(text_r[5:0]);
          last_nxt      = (char_cnt_r == LAST_CHAR);
          text_nxt      = {6'd0, text_r[63:6]};
          char_cnt_nxt  = char_cnt_r + 4'd1;
          if (char_cnt_r == LAST_CHAR) begin
            state_nxt = ST_TRACK;
          end
        end
      end
      default: begin
        state_nxt = ST_TRACK;
      end
    endcase
  end

  // sequencer control and disk sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_TRACK;
      d1_r        <= '0;
      d2_r        <= '0;
      char_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      d1_r        <= d1_nxt;
      d2_r        <= d2_nxt;
      char_cnt_r  <= char_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word and burst payload
  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    text_r  <= text_nxt;
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    chr_r   <= chr_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_track_index   = idx_r;
  assign out_checksum_high = hi_r;
  assign out_checksum_low  = lo_r;
  assign out_text_char     = chr_r;
  assign out_run_last      = last_r;

  // ---------------- checks ----------------
  `DITC_ASSERT_SAME(a_ev_no_overwrite, in_accept && at_end && ev_valid_r, ev_take, "track event overwritten")
  `DITC_ASSERT_SAME(a_take_only_idle, ev_take, state_r == ST_TRACK, "event taken during disk burst")
  `DITC_ASSERT_SAME(a_char_cnt_range, state_r == ST_TEXT, char_cnt_r <= LAST_CHAR, "text counter out of range")
  `DITC_ASSERT_NEXT(a_burst_clears, state_r == ST_TEXT && out_free && char_cnt_r == LAST_CHAR, state_r == ST_TRACK && d1_r == 32'd0 && d2_r == 32'd0 && out_run_last, "disk state not cleared after text")

endmodule

`default_nettype wire
